// ===== rtl/ft12gw_pkg.sv =====
// Shared types, constants and telegram tables of the FT1.2 group write framer.
`timescale 1ns / 1ps

package ft12gw_pkg;

    // Request queue depth between front and back
    localparam int QUEUE_DEPTH = 2;

    // Request kinds
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_FLOAT = 2'd1;

    // Framing bytes
    localparam logic [7:0] FT_START   = 8'h68;
    localparam logic [7:0] FT_END     = 8'h16;
    localparam logic [7:0] FCB_BIT    = 8'h20;
    localparam logic [7:0] CTRL_RESET = 8'h73;
    localparam logic [7:0] CTRL_DATA  = CTRL_RESET ^ FCB_BIT;
    localparam logic [7:0] LLOFF_LEN  = 8'h09;

    // APDU / NPDU bytes
    localparam logic [7:0] APDU_FLOAT  = 8'h80;
    localparam logic [7:0] APDU_OTHER  = 8'hFF;
    localparam logic [7:0] NPDU_FLOAT  = 8'h03;
    localparam logic [7:0] NPDU_BYTE   = 8'h01;

    // Two-byte float limits
    localparam logic [15:0]        FLOAT_INVALID = 16'h7FFF;
    localparam logic [25:0]        MANT_MAX      = 26'd2047;
    localparam logic signed [26:0] FLOAT_MIN     = -27'sd67108864;
    localparam logic signed [26:0] FLOAT_LIMIT   = 27'sd67076096;

    // One queued request, already classified and encoded
    typedef struct packed {
        logic       is_float;
        logic [7:0] dst_hi;
        logic [7:0] sub_addr;
        logic [7:0] apdu;
        logic [15:0] flt;
    } req_entry_t;

    // FT1.2 reset telegram
    function automatic logic [7:0] reset_tel_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h10;
            2'd1:    b = 8'h40;
            2'd2:    b = 8'h40;
            default: b = 8'h16;
        endcase
        return b;
    endfunction

    // Link-layer-on telegram
    function automatic logic [7:0] llon_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h68;
            4'd1:    b = 8'h09;
            4'd2:    b = 8'h09;
            4'd3:    b = 8'h68;
            4'd4:    b = 8'h73;
            4'd5:    b = 8'hF6;
            4'd6:    b = 8'h00;
            4'd7:    b = 8'h08;
            4'd8:    b = 8'h01;
            4'd9:    b = 8'h34;
            4'd10:   b = 8'h10;
            4'd11:   b = 8'h01;
            4'd12:   b = 8'h00;
            4'd13:   b = 8'hB7;
            4'd14:   b = 8'h16;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Link-layer-off body (between control byte and checksum)
    function automatic logic [7:0] lloff_body_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'hF6;
            3'd1:    b = 8'h00;
            3'd2:    b = 8'h08;
            3'd3:    b = 8'h01;
            3'd4:    b = 8'h34;
            3'd5:    b = 8'h10;
            3'd6:    b = 8'h01;
            default: b = 8'hF0;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/ft12gw_front.sv =====
// Front end: accepts requests, builds the address bytes and encodes the two-byte float.
`timescale 1ns / 1ps

module ft12gw_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_kind,
    input  logic [4:0]                s_main_grp,
    input  logic [2:0]                s_middle_group,
    input  logic [7:0]                s_sub_address,
    input  logic [7:0]                s_value_byte,
    input  logic signed [26:0]        s_value_hundredths,
    output logic                      q_push,
    output ft12gw_pkg::req_entry_t    q_data,
    input  logic                      q_full
);
    import ft12gw_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_NORM = 2'b10
    } front_state_t;

    front_state_t state_reg, state_next;
    logic        is_float_reg, is_float_next;
    logic [7:0]  dst_hi_reg, dst_hi_next;
    logic [7:0]  sub_reg, sub_next;
    logic [7:0]  apdu_reg, apdu_next;
    logic        neg_reg, neg_next;
    logic        ovf_reg, ovf_next;
    logic [25:0] mag_reg, mag_next;
    logic [3:0]  expo_reg, expo_next;

    logic        accept;
    logic        norm_busy;
    logic [26:0] neg_value;
    logic [10:0] mant;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign neg_value = 27'(-s_value_hundredths);
    // one shift a cycle until the magnitude fits the 11-bit mantissa
    assign norm_busy = is_float_reg && !ovf_reg && (mag_reg > MANT_MAX);
    assign mant      = neg_reg ? 11'(~mag_reg[10:0] + 11'd1) : mag_reg[10:0];

    // Queue entry
    always_comb begin
        q_data.is_float = is_float_reg;
        q_data.dst_hi   = dst_hi_reg;
        q_data.sub_addr = sub_reg;
        q_data.apdu     = apdu_reg;
        q_data.flt      = ovf_reg ? FLOAT_INVALID : {neg_reg, expo_reg, mant};
    end

    // Classify and normalize
    always_comb begin
        state_next    = state_reg;
        is_float_next = is_float_reg;
        dst_hi_next   = dst_hi_reg;
        sub_next      = sub_reg;
        apdu_next     = apdu_reg;
        neg_next      = neg_reg;
        ovf_next      = ovf_reg;
        mag_next      = mag_reg;
        expo_next     = expo_reg;
        q_push        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    is_float_next = (s_kind == KIND_FLOAT);
                    dst_hi_next   = {s_main_grp, s_middle_group};
                    sub_next      = s_sub_address;
                    if (s_kind == KIND_FLOAT) begin
                        apdu_next = APDU_FLOAT;
                    end else if (s_kind == KIND_BYTE) begin
                        apdu_next = s_value_byte;
                    end else begin
                        apdu_next = APDU_OTHER;
                    end
                    neg_next   = s_value_hundredths[26];
                    ovf_next   = (s_value_hundredths == FLOAT_MIN) ||
                                 (s_value_hundredths >= FLOAT_LIMIT);
                    mag_next   = s_value_hundredths[26] ? neg_value[25:0]
                                                        : s_value_hundredths[25:0];
                    expo_next  = 4'd0;
                    state_next = ST_NORM;
                end
            end
            ST_NORM: begin
                if (norm_busy) begin
                    mag_next  = {1'b0, mag_reg[25:1]};
                    expo_next = expo_reg + 4'd1;
                end else if (!q_full) begin
                    q_push     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        is_float_reg <= is_float_next;
        dst_hi_reg   <= dst_hi_next;
        sub_reg      <= sub_next;
        apdu_reg     <= apdu_next;
        neg_reg      <= neg_next;
        ovf_reg      <= ovf_next;
        mag_reg      <= mag_next;
        expo_reg     <= expo_next;
    end

`ifndef SYNTHESIS
    // an accepted request always goes to the normalize step
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_NORM))
        else $error("front: accepted request did not enter normalize");
    // each normalize step bumps the exponent by one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_NORM && norm_busy) |=> (expo_reg == 4'($past(expo_reg) + 4'd1)))
        else $error("front: exponent did not advance on shift");
`endif

endmodule

// ===== rtl/ft12gw_fifo.sv =====
// Small request queue between the front and back ends.
`timescale 1ns / 1ps

module ft12gw_fifo #(
    parameter int DEPTH = ft12gw_pkg::QUEUE_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  ft12gw_pkg::req_entry_t push_data,
    output logic                   full,
    input  logic                   pop,
    output ft12gw_pkg::req_entry_t head,
    output logic                   empty
);
    import ft12gw_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    req_entry_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/ft12gw_back.sv =====
// Back end: walks a request's telegrams, one byte a cycle unless m_ready stalls.
`timescale 1ns / 1ps

module ft12gw_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [15:0]            source_address,
    input  ft12gw_pkg::req_entry_t q_head,
    input  logic                   q_empty,
    output logic                   q_pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_out_byte,
    output logic                   m_last
);
    import ft12gw_pkg::*;

    req_entry_t  cur_reg, cur_next;
    logic        active_reg, active_next;
    logic [5:0]  pos_reg, pos_next;
    logic [7:0]  sum_reg, sum_next;
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_byte_reg, m_byte_next;
    logic        m_last_reg, m_last_next;

    logic [3:0]  blen;
    logic [5:0]  sum_pos;
    logic [5:0]  last_pos;
    logic [5:0]  off;
    logic [3:0]  body_idx;
    logic [5:0]  body_off;
    logic [7:0]  body_byte;
    logic [7:0]  gen_byte;
    logic        sum_set;
    logic        sum_add;
    logic        out_slot;

    assign blen     = cur_reg.is_float ? 4'd13 : 4'd11;
    assign sum_pos  = 6'd24 + {2'b00, blen};
    assign last_pos = 6'd40 + {2'b00, blen};
    assign off      = pos_reg - sum_pos - 6'd2;
    assign body_off = pos_reg - 6'd24;
    assign body_idx = body_off[3:0];
    assign out_slot = !m_valid_reg || m_ready;

    // cEMI body byte at body_idx
    always_comb begin
        case (body_idx)
            4'd0:    body_byte = 8'h11;
            4'd1:    body_byte = 8'h00;
            4'd2:    body_byte = 8'h9C;
            4'd3:    body_byte = 8'hE0;
            4'd4:    body_byte = source_address[15:8];
            4'd5:    body_byte = source_address[7:0];
            4'd6:    body_byte = cur_reg.dst_hi;
            4'd7:    body_byte = cur_reg.sub_addr;
            4'd8:    body_byte = cur_reg.is_float ? NPDU_FLOAT : NPDU_BYTE;
            4'd9:    body_byte = 8'h00;
            4'd10:   body_byte = cur_reg.apdu;
            4'd11:   body_byte = cur_reg.flt[15:8];
            4'd12:   body_byte = cur_reg.flt[7:0];
            default: body_byte = 8'h00;
        endcase
    end

    // Byte at pos_reg, with checksum start/accumulate flags
    always_comb begin
        gen_byte = 8'h00;
        sum_set  = 1'b0;
        sum_add  = 1'b0;
        if (pos_reg < 6'd4) begin
            gen_byte = reset_tel_byte(pos_reg[1:0]);
        end else if (pos_reg < 6'd19) begin
            gen_byte = llon_byte(4'(pos_reg - 6'd4));
        end else if (pos_reg == 6'd19 || pos_reg == 6'd22) begin
            gen_byte = FT_START;
        end else if (pos_reg < 6'd22) begin
            gen_byte = {4'd0, blen} + 8'd1;
        end else if (pos_reg == 6'd23) begin
            gen_byte = CTRL_DATA;
            sum_set  = 1'b1;
        end else if (pos_reg < sum_pos) begin
            gen_byte = body_byte;
            sum_add  = 1'b1;
        end else if (pos_reg == sum_pos) begin
            gen_byte = sum_reg;
        end else if (pos_reg == sum_pos + 6'd1) begin
            gen_byte = FT_END;
        end else begin
            // link-off telegram
            if (off == 6'd0 || off == 6'd3) begin
                gen_byte = FT_START;
            end else if (off < 6'd3) begin
                gen_byte = LLOFF_LEN;
            end else if (off == 6'd4) begin
                gen_byte = CTRL_RESET;
                sum_set  = 1'b1;
            end else if (off < 6'd13) begin
                gen_byte = lloff_body_byte(3'(off - 6'd5));
                sum_add  = 1'b1;
            end else if (off == 6'd13) begin
                gen_byte = sum_reg;
            end else begin
                gen_byte = FT_END;
            end
        end
    end

    // Sequencer and output register
    always_comb begin
        cur_next     = cur_reg;
        active_next  = active_reg;
        pos_next     = pos_reg;
        sum_next     = sum_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_byte_next  = m_byte_reg;
        m_last_next  = m_last_reg;
        q_pop        = 1'b0;
        if (!active_reg) begin
            if (!q_empty) begin
                q_pop       = 1'b1;
                cur_next    = q_head;
                active_next = 1'b1;
                pos_next    = 6'd0;
            end
        end else if (out_slot) begin
            m_valid_next = 1'b1;
            m_byte_next  = gen_byte;
            m_last_next  = (pos_reg == last_pos);
            pos_next     = pos_reg + 6'd1;
            if (sum_set) begin
                sum_next = gen_byte;
            end else if (sum_add) begin
                sum_next = sum_reg + gen_byte;
            end
            if (pos_reg == last_pos) begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
        end
        cur_reg    <= cur_next;
        pos_reg    <= pos_next;
        sum_reg    <= sum_next;
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_byte_reg;
    assign m_last     = m_last_reg;

`ifndef SYNTHESIS
    // position never runs past the end of the sequence
    assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (pos_reg <= last_pos))
        else $error("back: byte position past end of sequence");
    // every sequence closes with the FT1.2 end byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg) |-> (m_byte_reg == FT_END))
        else $error("back: last byte is not the end byte");
    // emitting the final byte releases the sequencer and marks last
    assert property (@(posedge aclk) disable iff (!aresetn)
        (active_reg && out_slot && pos_reg == last_pos) |=> (!active_reg && m_last_reg))
        else $error("back: final byte did not close the request");
`endif

endmodule

// ===== rtl/ft12_group_write_framer_top.sv =====
// Top level of the FT1.2 group write framer: config register, front, queue and back.
`timescale 1ns / 1ps

// An accepted request passes the front registers, the queue and the back request register
//   before its first byte is registered at the output; float requests also run the normalize
//   loop in the front (up to 15 mantissa shifts). Each request gives 52 bytes (54 for float),
//   one byte a cycle while m_ready does not stall; the next queued request is fetched after its last byte.
// Reset (synchronous, active low): queue emptied, sequencer idle, source address 0.
module ft12_group_write_framer_top #(
    parameter int QUEUE_DEPTH = ft12gw_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic [4:0]         s_main_grp,
    input  logic [2:0]         s_middle_group,
    input  logic [7:0]         s_sub_address,
    input  logic [7:0]         s_value_byte,
    input  logic signed [26:0] s_value_hundredths,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_byte,
    output logic               m_last
);
    import ft12gw_pkg::*;

    logic [15:0] source_address_reg, source_address_next;
    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_empty;
    req_entry_t  q_in;
    req_entry_t  q_head;

    // Source address register
    assign cfg_ready = 1'b1;
    assign source_address_next = (cfg_valid && cfg_ready) ? cfg_data : source_address_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_address_reg <= '0;
        end else begin
            source_address_reg <= source_address_next;
        end
    end

    ft12gw_front u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_kind             (s_kind),
        .s_main_grp         (s_main_grp),
        .s_middle_group     (s_middle_group),
        .s_sub_address      (s_sub_address),
        .s_value_byte       (s_value_byte),
        .s_value_hundredths (s_value_hundredths),
        .q_push             (q_push),
        .q_data             (q_in),
        .q_full             (q_full)
    );

    ft12gw_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    ft12gw_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .source_address (source_address_reg),
        .q_head         (q_head),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_last         (m_last)
    );

endmodule

// ===== test/ft12_group_write_framer_top_tb.sv =====
// Self-checking testbench for the FT1.2 group write framer: predicts each telegram byte.
`timescale 1ns / 1ps

module ft12_group_write_framer_top_tb;
    import ft12gw_pkg::*;

    // Kinds the package leaves unnamed
    localparam logic [1:0] KIND_OTHER = 2'd2;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    // cEMI header and transport bytes of the data frame
    localparam logic [7:0] CEMI_LDATA_REQ = 8'h11;
    localparam logic [7:0] CEMI_ADD_INFO  = 8'h00;
    localparam logic [7:0] CEMI_CTRL1     = 8'h9C;
    localparam logic [7:0] CEMI_CTRL2     = 8'hE0;
    localparam logic [7:0] CEMI_TPCI      = 8'h00;

    // Fixed telegrams, first byte in the top bits
    localparam logic [31:0]  RESET_SEQ  = 32'h10_40_40_16;
    localparam logic [119:0] LINK_ON_SEQ =
        120'h68_09_09_68_73_F6_00_08_01_34_10_01_00_B7_16;
    localparam logic [63:0]  LINK_OFF_BODY = 64'hF6_00_08_01_34_10_01_F0;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]         kind;
        logic [4:0]         main_grp;
        logic [2:0]         middle_group;
        logic [7:0]         sub_address;
        logic [7:0]         value_byte;
        logic signed [26:0] hundredths;
    } group_write_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } tel_byte_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [15:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_kind = '0;
    logic [4:0]         s_main_grp = '0;
    logic [2:0]         s_middle_group = '0;
    logic [7:0]         s_sub_address = '0;
    logic [7:0]         s_value_byte = '0;
    logic signed [26:0] s_value_hundredths = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [7:0]         m_out_byte;
    logic               m_last;

    // Predictor state
    logic [7:0]  link_ctrl = CTRL_RESET;
    logic [15:0] source_addr = '0;

    group_write_t request_q[$];
    tel_byte_t    telegram_q[$];
    group_write_t granted;
    tel_byte_t    want;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    ft12_group_write_framer_top dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_kind             (s_kind),
        .s_main_grp         (s_main_grp),
        .s_middle_group     (s_middle_group),
        .s_sub_address      (s_sub_address),
        .s_value_byte       (s_value_byte),
        .s_value_hundredths (s_value_hundredths),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_out_byte         (m_out_byte),
        .m_last             (m_last)
    );

    always #2 aclk = ~aclk;

    // Two-octet float: 11-bit mantissa, 4-bit exponent, sign on top
    function automatic logic [15:0] dpt9_encode(input logic signed [26:0] hund);
        int          v;
        int          mag;
        int          expo;
        logic        neg;
        logic [10:0] mant;
        v = hund;
        if (v <= int'(FLOAT_MIN) || v >= int'(FLOAT_LIMIT))
            return FLOAT_INVALID;
        neg = (v < 0);
        mag = neg ? -v : v;
        expo = 0;
        while (mag > 2047) begin
            mag = mag >> 1;
            expo++;
        end
        mant = mag[10:0];
        if (neg)
            mant = ~mant + 11'd1;
        return {neg, expo[3:0], mant};
    endfunction

    // Expected byte stream of one request: reset, link on, data frame, link off
    task automatic predict_frames(input group_write_t req);
        logic [7:0]  body [0:12];
        logic [7:0]  seq [$];
        logic [7:0]  cks;
        logic [7:0]  len_byte;
        logic [15:0] flt;
        int          body_len;
        tel_byte_t   tb;
        body[0] = CEMI_LDATA_REQ;
        body[1] = CEMI_ADD_INFO;
        body[2] = CEMI_CTRL1;
        body[3] = CEMI_CTRL2;
        body[4] = source_addr[15:8];
        body[5] = source_addr[7:0];
        body[6] = {req.main_grp, req.middle_group};
        body[7] = req.sub_address;
        body[9] = CEMI_TPCI;
        if (req.kind == KIND_FLOAT) begin
            flt = dpt9_encode(req.hundredths);
            body[8] = NPDU_FLOAT;
            body[10] = APDU_FLOAT;
            body[11] = flt[15:8];
            body[12] = flt[7:0];
            body_len = 13;
        end else begin
            body[8] = NPDU_BYTE;
            body[10] = (req.kind == KIND_BYTE) ? req.value_byte : APDU_OTHER;
            body_len = 11;
        end

        for (int i = 0; i < 4; i++)
            seq.push_back(RESET_SEQ[8*(3-i) +: 8]);
        for (int i = 0; i < 15; i++)
            seq.push_back(LINK_ON_SEQ[8*(14-i) +: 8]);

        // data frame with the frame count bit flipped
        link_ctrl = link_ctrl ^ FCB_BIT;
        len_byte = 8'(body_len + 1);
        seq.push_back(FT_START);
        seq.push_back(len_byte);
        seq.push_back(len_byte);
        seq.push_back(FT_START);
        seq.push_back(link_ctrl);
        cks = link_ctrl;
        for (int i = 0; i < body_len; i++) begin
            seq.push_back(body[i]);
            cks = cks + body[i];
        end
        seq.push_back(cks);
        seq.push_back(FT_END);

        // link off, control flipped back
        link_ctrl = link_ctrl ^ FCB_BIT;
        seq.push_back(FT_START);
        seq.push_back(LLOFF_LEN);
        seq.push_back(LLOFF_LEN);
        seq.push_back(FT_START);
        seq.push_back(link_ctrl);
        cks = link_ctrl;
        for (int i = 0; i < 8; i++) begin
            seq.push_back(LINK_OFF_BODY[8*(7-i) +: 8]);
            cks = cks + LINK_OFF_BODY[8*(7-i) +: 8];
        end
        seq.push_back(cks);
        seq.push_back(FT_END);

        for (int i = 0; i < seq.size(); i++) begin
            tb.data = seq[i];
            tb.last = (i == seq.size() - 1);
            telegram_q.push_back(tb);
        end
    endtask

    function automatic group_write_t make_request(input logic [1:0] kind,
                                                  input logic [4:0] main_grp,
                                                  input logic [2:0] middle_group,
                                                  input logic [7:0] sub_address,
                                                  input logic [7:0] value_byte,
                                                  input int hund);
        group_write_t r;
        r.kind = kind;
        r.main_grp = main_grp;
        r.middle_group = middle_group;
        r.sub_address = sub_address;
        r.value_byte = value_byte;
        r.hundredths = 27'(hund);
        return r;
    endfunction

    // Random request, floats spread over exponents, small values and range edges
    function automatic group_write_t random_request();
        group_write_t r;
        int           pick;
        int           mag;
        pick = $urandom_range(9);
        if (pick < 4)
            r.kind = KIND_FLOAT;
        else if (pick < 7)
            r.kind = KIND_BYTE;
        else if (pick < 9)
            r.kind = KIND_OTHER;
        else
            r.kind = KIND_SPARE;
        r.main_grp = 5'($urandom_range(31));
        r.middle_group = 3'($urandom_range(7));
        r.sub_address = 8'($urandom_range(255));
        r.value_byte = 8'($urandom_range(255));
        case ($urandom_range(3))
            0: r.hundredths = 27'($urandom);
            1: r.hundredths = 27'(int'($urandom_range(4000)) - 2000);
            2: begin
                if ($urandom_range(1))
                    r.hundredths = 27'(int'(FLOAT_LIMIT) - 2 + int'($urandom_range(3)));
                else
                    r.hundredths = 27'(int'(FLOAT_MIN) + int'($urandom_range(2)));
            end
            default: begin
                mag = $urandom_range(2047) << $urandom_range(15);
                r.hundredths = 27'($urandom_range(1) ? -mag : mag);
            end
        endcase
        return r;
    endfunction

    // Source address write, only while the block is idle
    task automatic write_source(input logic [15:0] addr);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= addr;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        source_addr = addr;
    endtask

    task automatic drain();
        while (request_q.size() != 0 || telegram_q.size() != 0 || s_valid)
            @(posedge aclk);
    endtask

    task automatic note_mismatch(input string what);
        if (mismatch_count < 10)
            $display("%0t: mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                granted = request_q.pop_front();
                predict_frames(granted);
            end
            if (s_valid && !s_ready) begin
                // hold the request until taken
            end else if (request_q.size() != 0 &&
                         $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_kind <= request_q[0].kind;
                s_main_grp <= request_q[0].main_grp;
                s_middle_group <= request_q[0].middle_group;
                s_sub_address <= request_q[0].sub_address;
                s_value_byte <= request_q[0].value_byte;
                s_value_hundredths <= request_q[0].hundredths;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Byte monitor and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (telegram_q.size() == 0) begin
                    note_mismatch($sformatf("unexpected byte %02h last %0b",
                                            m_out_byte, m_last));
                end else begin
                    want = telegram_q.pop_front();
                    if (want.data !== m_out_byte || want.last !== m_last)
                        note_mismatch($sformatf("byte exp %02h got %02h, last exp %0b got %0b",
                                                want.data, m_out_byte, want.last, m_last));
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Timeout
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("ft12_group_write_framer_top_tb: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes, every kind, float corners
        send_idle_pct = 29;
        recv_idle_pct = 64;
        write_source(16'h0000);
        request_q.push_back(make_request(KIND_BYTE, 5'd0, 3'd0, 8'h00, 8'h00, 0));
        request_q.push_back(make_request(KIND_BYTE, 5'd31, 3'd7, 8'hFF, 8'hFF, 0));
        request_q.push_back(make_request(KIND_BYTE, 5'd17, 3'd3, 8'hA5, 8'h5A, -1));
        request_q.push_back(make_request(KIND_OTHER, 5'd1, 3'd2, 8'h03, 8'h12, 0));
        request_q.push_back(make_request(KIND_SPARE, 5'd31, 3'd0, 8'h80, 8'h34, 0));
        request_q.push_back(make_request(KIND_FLOAT, 5'd0, 3'd7, 8'h00, 8'h00, 0));
        request_q.push_back(make_request(KIND_FLOAT, 5'd2, 3'd1, 8'h01, 8'h00, 1));
        request_q.push_back(make_request(KIND_FLOAT, 5'd2, 3'd1, 8'h02, 8'h00, -1));
        request_q.push_back(make_request(KIND_FLOAT, 5'd3, 3'd4, 8'h10, 8'h00, 2047));
        request_q.push_back(make_request(KIND_FLOAT, 5'd3, 3'd4, 8'h11, 8'h00, 2048));
        request_q.push_back(make_request(KIND_FLOAT, 5'd3, 3'd4, 8'h12, 8'h00, -2048));
        request_q.push_back(make_request(KIND_FLOAT, 5'd3, 3'd4, 8'h13, 8'h00, -2049));
        request_q.push_back(make_request(KIND_FLOAT, 5'd4, 3'd5, 8'h20, 8'hFF, 2150));
        request_q.push_back(make_request(KIND_FLOAT, 5'd4, 3'd5, 8'h21, 8'hFF, -2730));
        request_q.push_back(make_request(KIND_FLOAT, 5'd5, 3'd6, 8'h30, 8'h00, 67076095));
        request_q.push_back(make_request(KIND_FLOAT, 5'd5, 3'd6, 8'h31, 8'h00, 67076096));
        request_q.push_back(make_request(KIND_FLOAT, 5'd5, 3'd6, 8'h32, 8'h00, 67108863));
        request_q.push_back(make_request(KIND_FLOAT, 5'd6, 3'd7, 8'h40, 8'h00, -67108864));
        request_q.push_back(make_request(KIND_FLOAT, 5'd6, 3'd7, 8'h41, 8'h00, -67108863));
        request_q.push_back(make_request(KIND_FLOAT, 5'd6, 3'd7, 8'h42, 8'h00, -67076096));
        drain();

        // Random, all-ones source
        write_source(16'hFFFF);
        repeat (115) request_q.push_back(random_request());
        drain();

        // Random, idling swapped, random source
        send_idle_pct = 64;
        recv_idle_pct = 29;
        write_source(16'($urandom_range(65535)));
        repeat (115) request_q.push_back(random_request());
        drain();

        // Random, full rate
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_source(16'($urandom_range(65535)));
        repeat (120) request_q.push_back(random_request());
        drain();

        repeat (16) @(posedge aclk);
        if (mismatch_count == 0)
            $display("ft12_group_write_framer_top_tb: PASS");
        else
            $display("ft12_group_write_framer_top_tb: FAIL");
        $finish;
    end

endmodule
